### hw/rtl/tcst_pkg.sv
// Shared constants, types and opcodes for the touch contact slot tracker.
package tcst_pkg;

  // Slot count and derived index width
  localparam int SLOTS  = 8;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Operation codes
  localparam logic [1:0] OP_EVENT = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Input item
  typedef struct packed {
    logic [1:0]          operation;
    logic signed [31:0]  contact_id;
    logic signed [15:0]  pos_x;
    logic signed [15:0]  pos_y;
    logic                is_down;
    logic [4:0]          slot_index;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic                accepted;
    logic [4:0]          slot_taken;
    logic [5:0]          down_count;
    logic signed [15:0]  read_x;
    logic signed [15:0]  read_y;
    logic                read_down;
  } out_item_t;

endpackage

### hw/rtl/tcst_if.sv
// Valid/ready channel interfaces for input items and result items.
interface tcst_in_if import tcst_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tcst_out_if import tcst_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/touch_contact_slot_tracker.sv
// Top level: input register, slot file and result register of the slot tracker.
//
//   channel  | dir | payload     | transfer
//   ---------+-----+-------------+----------------------------
//   in_ch    | in  | in_item_t   | valid && ready at clk rise
//   out_ch   | out | out_item_t  | valid && ready at clk rise
//
// One item per cycle sustained while results are taken; each item passes the input register,
// then the result register. Slot match, first-free select and the down count settle
// combinationally between the input register and the result register.
// Synchronous reset clears all slots at once; no clearing sweep.
// A stalled result holds; the input register keeps taking items until
// both registers are full.
module touch_contact_slot_tracker import tcst_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tcst_in_if.sink    in_ch,
  tcst_out_if.source out_ch
);

  logic      s1_v_r, s1_v_nxt;
  in_item_t  s1_item_r;
  logic      out_v_r, out_v_nxt;
  out_item_t out_item_r;
  out_item_t res;
  logic      out_free, s1_go, in_xfer;

  assign out_free    = !out_v_r || out_ch.ready;
  assign s1_go       = s1_v_r && out_free;
  assign in_ch.ready = !s1_v_r || s1_go;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign s1_v_nxt  = in_xfer || (s1_v_r && !s1_go);
  assign out_v_nxt = s1_go || (out_v_r && !out_ch.ready);

  tcst_slot_file u_slots (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd_go (s1_go),
    .cmd    (s1_item_r),
    .res    (res)
  );

  // Advance valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Load payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_ch.data;
    end
    if (s1_go) begin
      out_item_r <= res;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_item_r;

endmodule

### hw/rtl/tcst_slot_file.sv
// Slot state registers with match, first-free select, update and read logic.
module tcst_slot_file import tcst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_go,
  input  in_item_t  cmd,
  output out_item_t res
);

  logic [SLOTS-1:0] used_r, used_nxt;
  logic [SLOTS-1:0] down_r, down_nxt;
  logic [31:0]      contact_r [SLOTS];
  logic [31:0]      contact_nxt [SLOTS];
  logic [15:0]      x_r [SLOTS];
  logic [15:0]      x_nxt [SLOTS];
  logic [15:0]      y_r [SLOTS];
  logic [15:0]      y_nxt [SLOTS];
  logic [5:0]       count_r, count_nxt;

  logic              match_hit, free_hit;
  logic [SLOT_W-1:0] match_idx, free_idx, sel_idx;
  logic              sel_hit;
  logic              rd_in_range;
  logic [SLOT_W-1:0] rd_idx;

  // Find lowest used slot with matching id and lowest unused slot
  always_comb begin
    match_hit = 1'b0;
    match_idx = '0;
    free_hit  = 1'b0;
    free_idx  = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (used_r[k] && (contact_r[k] == cmd.contact_id)) begin
        match_hit = 1'b1;
        match_idx = SLOT_W'(k);
      end
      if (!used_r[k]) begin
        free_hit = 1'b1;
        free_idx = SLOT_W'(k);
      end
    end
  end

  assign sel_hit = match_hit || (free_hit && cmd.is_down);
  assign sel_idx = match_hit ? match_idx : free_idx;

  assign rd_in_range = ({1'b0, cmd.slot_index} < 6'(SLOTS));
  assign rd_idx      = cmd.slot_index[SLOT_W-1:0];

  // Next state and result for the current command
  always_comb begin
    used_nxt    = used_r;
    down_nxt    = down_r;
    contact_nxt = contact_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    count_nxt   = count_r;
    res         = '0;

    unique case (cmd.operation)
      OP_EVENT: begin
        if (sel_hit) begin
          used_nxt[sel_idx]    = 1'b1;
          down_nxt[sel_idx]    = cmd.is_down;
          contact_nxt[sel_idx] = cmd.contact_id;
          x_nxt[sel_idx]       = cmd.pos_x;
          y_nxt[sel_idx]       = cmd.pos_y;
          count_nxt            = 6'($countones(used_nxt & down_nxt));
          res.accepted         = 1'b1;
          res.slot_taken       = 5'(sel_idx);
        end
      end
      OP_READ: begin
        if (rd_in_range) begin
          res.read_x    = x_r[rd_idx];
          res.read_y    = y_r[rd_idx];
          res.read_down = down_r[rd_idx];
        end
      end
      OP_CLEAR: begin
        used_nxt  = '0;
        down_nxt  = '0;
        count_nxt = '0;
        for (int k = 0; k < SLOTS; k++) begin
          contact_nxt[k] = '1;
          x_nxt[k]       = '0;
          y_nxt[k]       = '0;
        end
      end
      default: begin
        // unused code: no change, zero result fields but the down count
      end
    endcase

    res.down_count = count_nxt;
  end

  // Hold state; advance on each command transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      down_r  <= '0;
      count_r <= '0;
      for (int k = 0; k < SLOTS; k++) begin
        x_r[k] <= '0;
        y_r[k] <= '0;
      end
    end else if (cmd_go) begin
      used_r  <= used_nxt;
      down_r  <= down_nxt;
      count_r <= count_nxt;
      for (int k = 0; k < SLOTS; k++) begin
        x_r[k] <= x_nxt[k];
        y_r[k] <= y_nxt[k];
      end
    end
  end

  // Contact ids only compare against used slots
  always_ff @(posedge clk) begin
    if (cmd_go) begin
      for (int k = 0; k < SLOTS; k++) begin
        contact_r[k] <= contact_nxt[k];
      end
    end
  end

endmodule

### hw/rtl/tcst_checker.sv
// Port-level assertions for the slot tracker and the bind that attaches them.
module tcst_checker import tcst_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Stored event carries an in-range slot and no read data
  a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |->
      ({1'b0, out_data.slot_taken} < 6'(SLOTS)) && (out_data.read_x == '0) &&
      (out_data.read_y == '0) && !out_data.read_down)
    else $error("accepted result malformed");

  // Rejected or non-event results report slot zero
  a_reject_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted |-> out_data.slot_taken == '0)
    else $error("slot reported without acceptance");

  // Down count never exceeds the slot count
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.down_count <= 6'(SLOTS))
    else $error("down count out of range");

endmodule

bind touch_contact_slot_tracker tcst_checker u_tcst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

### tb/touch_contact_slot_tracker_tb.sv
// Self-checking testbench for the touch contact slot tracker: slot predictor, scoreboard, drivers.
`timescale 1ns / 1ps

module touch_contact_slot_tracker_tb;
  import tcst_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CLK_HALF    = 6;
  localparam int         RESET_TICKS = 9;
  localparam int         HOLD_CYCLES = 40;
  localparam int         STALL_LIMIT = 1000;
  localparam int         TAIL_CYCLES = 10;
  localparam int         REPORT_MAX  = 10;
  localparam int         POOL_SIZE   = 10;

  // Predicts every result from its own copy of the slot file and checks results in order.
  class slot_tracker_scoreboard;
    logic              used [SLOTS];
    logic              down [SLOTS];
    logic signed [31:0] owner [SLOTS];
    logic signed [15:0] xpos [SLOTS];
    logic signed [15:0] ypos [SLOTS];
    logic [5:0]         pressed;
    out_item_t          pending_slot_results[$];
    int failures;
    int checked;
    int stored;
    int rejected;
    int reads;
    int far_reads;
    int clears;
    int full_rejects;
    int peak_pressed;

    function new();
      failures = 0;
      checked = 0;
      stored = 0;
      rejected = 0;
      reads = 0;
      far_reads = 0;
      clears = 0;
      full_rejects = 0;
      peak_pressed = 0;
      wipe_slots();
    endfunction

    function void wipe_slots();
      for (int k = 0; k < SLOTS; k++) begin
        used[k]  = 1'b0;
        down[k]  = 1'b0;
        owner[k] = -32'sd1;
        xpos[k]  = '0;
        ypos[k]  = '0;
      end
      pressed = '0;
    endfunction

    // Apply one input to the slot file and return the result it produces.
    function out_item_t track_contact(in_item_t it);
      out_item_t r;
      int        hit;
      int        tally;
      int        occupied;
      r = '0;
      case (it.operation)
        OP_EVENT: begin
          hit = -1;
          occupied = 0;
          for (int k = 0; k < SLOTS; k++) begin
            if (hit < 0 && used[k] && owner[k] == it.contact_id) hit = k;
            if (used[k]) occupied++;
          end
          if (hit < 0 && it.is_down) begin
            for (int k = 0; k < SLOTS; k++) begin
              if (hit < 0 && !used[k]) hit = k;
            end
          end
          if (hit >= 0) begin
            used[hit]  = 1'b1;
            owner[hit] = it.contact_id;
            xpos[hit]  = it.pos_x;
            ypos[hit]  = it.pos_y;
            down[hit]  = it.is_down;
            tally = 0;
            for (int k = 0; k < SLOTS; k++) begin
              if (used[k] && down[k]) tally++;
            end
            pressed = tally[5:0];
            if (tally > peak_pressed) peak_pressed = tally;
            r.accepted   = 1'b1;
            r.slot_taken = hit[4:0];
            stored++;
          end else begin
            rejected++;
            if (it.is_down && occupied == SLOTS) full_rejects++;
          end
        end
        OP_READ: begin
          reads++;
          if (it.slot_index < SLOTS) begin
            r.read_x    = xpos[it.slot_index];
            r.read_y    = ypos[it.slot_index];
            r.read_down = down[it.slot_index];
          end else begin
            far_reads++;
          end
        end
        OP_CLEAR: begin
          clears++;
          wipe_slots();
        end
        default: ;
      endcase
      r.down_count = pressed;
      return r;
    endfunction

    function void note_input(in_item_t it);
      pending_slot_results.push_back(track_contact(it));
    endfunction

    function int pending_count();
      return pending_slot_results.size();
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      failures++;
      if (failures <= REPORT_MAX)
        $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    endfunction

    // Compare one result transfer with the oldest prediction.
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_slot_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("[%0t] result with nothing pending: 0x%0h", $realtime, got);
        return;
      end
      want = pending_slot_results.pop_front();
      checked++;
      if (got.accepted !== want.accepted)     flag("accepted", want.accepted, got.accepted);
      if (got.slot_taken !== want.slot_taken) flag("slot_taken", want.slot_taken, got.slot_taken);
      if (got.down_count !== want.down_count) flag("down_count", want.down_count, got.down_count);
      if (got.read_x !== want.read_x)         flag("read_x", want.read_x, got.read_x);
      if (got.read_y !== want.read_y)         flag("read_y", want.read_y, got.read_y);
      if (got.read_down !== want.read_down)   flag("read_down", want.read_down, got.read_down);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tcst_in_if  in_ch ();
  tcst_out_if out_ch ();

  touch_contact_slot_tracker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  slot_tracker_scoreboard sb;
  int                 rx_idle_pct;
  int                 hold_seq;
  int                 hold_seen = 0;
  int                 stall_cycles = 0;
  logic signed [31:0] id_pool [POOL_SIZE];

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Record transfers on both channels; results are checked before the new input is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      if (in_ch.valid && in_ch.ready) sb.note_input(in_ch.data);
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result receiver: random back-pressure, or a long hold when the sender asks for one
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic in_item_t touch(logic [1:0] op, logic signed [31:0] id,
                                     logic signed [15:0] x, logic signed [15:0] y,
                                     logic dn, logic [4:0] idx);
    in_item_t it;
    it.operation  = op;
    it.contact_id = id;
    it.pos_x      = x;
    it.pos_y      = y;
    it.is_down    = dn;
    it.slot_index = idx;
    return it;
  endfunction

  // Draw a fresh set of contact ids, sometimes with the extreme values
  function automatic void refill_ids();
    for (int k = 0; k < POOL_SIZE; k++) id_pool[k] = $urandom;
    case ($urandom_range(3))
      0: id_pool[0] = 32'sh8000_0000;
      1: id_pool[0] = 32'sh7fff_ffff;
      2: id_pool[0] = -32'sd1;
      default: ;
    endcase
  endfunction

  // Mostly events from a small id set so contacts come back to their slots
  function automatic in_item_t random_touch();
    in_item_t it;
    int       pick;
    it.contact_id = $urandom;
    it.pos_x      = 16'($urandom);
    it.pos_y      = 16'($urandom);
    it.is_down    = 1'($urandom);
    it.slot_index = 5'($urandom);
    pick = $urandom_range(99);
    if (pick < 62) begin
      it.operation = OP_EVENT;
      if ($urandom_range(9) != 0) it.contact_id = id_pool[$urandom_range(POOL_SIZE - 1)];
      it.is_down = ($urandom_range(3) != 0);
    end else if (pick < 92) begin
      it.operation = OP_READ;
      if ($urandom_range(4) != 0) it.slot_index = 5'($urandom_range(SLOTS - 1));
    end else if (pick < 97) begin
      it.operation = OP_CLEAR;
      refill_ids();
    end else begin
      it.operation = OP_UNUSED;
    end
    return it;
  endfunction

  // Offer one item, idling first at random; returns after its transfer
  task automatic offer(input in_item_t it, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.data  <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int tx_idle, input int rx_idle,
                           input bit with_hold);
    rx_idle_pct = rx_idle;
    for (int n = 0; n < count; n++) begin
      if (with_hold && n == 40) hold_seq <= hold_seq + 1;
      if (with_hold && n >= 40 && n < 80) offer(random_touch(), 0);
      else offer(random_touch(), tx_idle);
    end
    drain_results();
  endtask

  task automatic run_directed();
    rx_idle_pct = 54;
    // reads after reset, in and out of range
    offer(touch(OP_READ, 0, 0, 0, 0, 5'd0), 37);
    offer(touch(OP_READ, 0, 0, 0, 0, 5'd31), 37);
    offer(touch(OP_READ, 0, 0, 0, 0, 5'(SLOTS)), 37);
    // lift from an unknown contact, id equal to the reset id: rejected
    offer(touch(OP_EVENT, -32'sd1, 16'sd5, 16'sd6, 1'b0, 5'd0), 37);
    offer(touch(OP_EVENT, -32'sd1, 16'sh7fff, 16'sh8000, 1'b1, 5'd0), 37);
    offer(touch(OP_EVENT, 32'sh8000_0000, 16'sh8000, 16'sh7fff, 1'b1, 5'd0), 37);
    offer(touch(OP_EVENT, 32'sh7fff_ffff, 16'sd1, 16'sd2, 1'b0, 5'd0), 37);
    offer(touch(OP_EVENT, 32'sh7fff_ffff, -16'sd1, -16'sd1, 1'b1, 5'd0), 37);
    // lift a contact, then press it again in the same slot
    offer(touch(OP_EVENT, 32'sh8000_0000, 16'sd100, 16'sd200, 1'b0, 5'd0), 37);
    offer(touch(OP_READ, 0, 0, 0, 0, 5'd1), 37);
    offer(touch(OP_EVENT, 32'sh8000_0000, 16'sd101, 16'sd201, 1'b1, 5'd0), 37);
    // fill every slot, then a new press is turned away
    for (int k = 3; k < SLOTS; k++)
      offer(touch(OP_EVENT, 100 + k, 16'(k * 16), 16'(-k * 16), 1'b1, 5'd0), 37);
    offer(touch(OP_EVENT, 32'sd999, 16'sd7, 16'sd7, 1'b1, 5'd0), 37);
    offer(touch(OP_READ, 0, 0, 0, 0, 5'(SLOTS - 1)), 37);
    offer(touch(OP_UNUSED, 32'sh5a5a_a5a5, 16'sh7fff, 16'sh7fff, 1'b1, 5'd2), 37);
    // clear, then the slot file reads as after reset
    offer(touch(OP_CLEAR, 32'sd3, 16'sd3, 16'sd3, 1'b1, 5'd3), 37);
    offer(touch(OP_READ, 0, 0, 0, 0, 5'd2), 37);
    offer(touch(OP_EVENT, 32'sh7fff_ffff, 16'sd9, 16'sd9, 1'b1, 5'd0), 37);
    drain_results();
  endtask

  // Stimulus and end of run
  initial begin
    sb = new();
    hold_seq = 0;
    rx_idle_pct = 54;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    rst_n <= 1'b0;
    refill_ids();
    repeat (RESET_TICKS) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_phase(225, 37, 54, 1'b0);
    run_phase(225, 54, 37, 1'b0);
    run_phase(230, 0, 0, 1'b1);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d results: %0d contacts stored, %0d rejected (%0d with all slots taken)",
             sb.checked, sb.stored, sb.rejected, sb.full_rejects);
    $display("  %0d slot reads (%0d past the last slot), %0d clears, peak of %0d contacts down",
             sb.reads, sb.far_reads, sb.clears, sb.peak_pressed);
    if (sb.failures == 0 && sb.pending_count() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.failures, sb.pending_count());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
